FILE: src/dmcr_pkg.sv
// ----------------------------------------------------------------------------
// Dashed midpoint circle rasterizer package
// Shared widths, reset values and codes for the rasterizer and its channels.
// ----------------------------------------------------------------------------
package dmcr_pkg;

  // Default geometry widths.
  localparam int unsigned COORD_BITS_DEF  = 12;
  localparam int unsigned RADIUS_BITS_DEF = 10;

  // Configuration register file.
  localparam int unsigned CFG_DATA_BITS = 8;
  localparam int unsigned CFG_IDX_BITS  = 1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_DASH_LENGTH = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GAP_LENGTH  = 1'b1;

  localparam logic [CFG_DATA_BITS-1:0] DASH_LENGTH_RST = 8'd5;
  localparam logic [CFG_DATA_BITS-1:0] GAP_LENGTH_RST  = 8'd3;

  // Dash run counter width.
  localparam int unsigned RUN_BITS = 9;

  // Request codes.
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

endpackage

FILE: src/dmcr_ifs.sv
// ----------------------------------------------------------------------------
// Dashed midpoint circle rasterizer channels
// Valid/ready request and pixel channels with source and sink views.
// ----------------------------------------------------------------------------
interface dmcr_req_if #(
  parameter int unsigned COORD_BITS  = dmcr_pkg::COORD_BITS_DEF,
  parameter int unsigned RADIUS_BITS = dmcr_pkg::RADIUS_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic signed [COORD_BITS-1:0]  center_x;
  logic signed [COORD_BITS-1:0]  center_y;
  logic        [RADIUS_BITS-1:0] radius;

  modport source (output valid, req_type, center_x, center_y, radius, input ready);
  modport sink   (input valid, req_type, center_x, center_y, radius, output ready);
endinterface

interface dmcr_pix_if #(
  parameter int unsigned COORD_BITS = dmcr_pkg::COORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [COORD_BITS:0]  pixel_x;
  logic signed [COORD_BITS:0]  pixel_y;
  logic                        lit;
  logic                        last;
  logic                        done_res;

  modport source (output valid, pixel_x, pixel_y, lit, last, done_res, input ready);
  modport sink   (input valid, pixel_x, pixel_y, lit, last, done_res, output ready);
endinterface

FILE: src/dashed_midpoint_circle_rasterizer.sv
// ----------------------------------------------------------------------------
// Dashed midpoint circle rasterizer
// Walks the first octant of a circle with the midpoint decision and emits
// the mirrored points, each marked lit or blank by a dash/gap pattern.
// ----------------------------------------------------------------------------
// A start item takes the center and radius and produces four results, the
// axis points above, below, right and left of the center, all lit. Each step
// item moves one column along the first octant and produces eight results,
// the mirrored points of the new column, sharing one lit flag set by the
// dash/gap run counter. A step item while no circle is in progress produces
// one blank result at the origin, marked done. The last flag marks the final
// result of an item, and done_res is set on every result of the item that
// finishes the circle. Results leave through a single output register, one
// per cycle while the output is ready, so a start item holds it for 4 results,
// a step item 8 and an idle step 1; the output port sets the sustained rate.
// The circle state is updated when an item is accepted, and the next item is
// accepted in the same cycle that the last result of the current one is
// loaded into the output register, so the output never runs dry between
// items. Configuration writes may only be made while the block is idle.
// ----------------------------------------------------------------------------
module dashed_midpoint_circle_rasterizer #(
  parameter int unsigned COORD_BITS  = dmcr_pkg::COORD_BITS_DEF,
  parameter int unsigned RADIUS_BITS = dmcr_pkg::RADIUS_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dmcr_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [dmcr_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  dmcr_req_if.sink                          req_i,
  dmcr_pix_if.source                        pix_o
);
  import dmcr_pkg::*;

  // The decision term stays within about twice the radius in magnitude.
  localparam int unsigned DW = RADIUS_BITS + 3;
  localparam int unsigned PW = COORD_BITS + 1;

  localparam logic [DW-1:0] DEC_ONE      = DW'(1);
  localparam logic [DW-1:0] DEC_EAST_INC = DW'(3);
  localparam logic [DW-1:0] DEC_DIAG_INC = DW'(5);

  localparam logic [2:0] PT_FIRST      = 3'd0;
  localparam logic [2:0] PT_START_JUMP = 3'd1;
  localparam logic [2:0] PT_START_NEXT = 3'd4;
  localparam logic [2:0] PT_START_LAST = 3'd5;
  localparam logic [2:0] PT_STEP_LAST  = 3'd7;

  typedef enum logic [1:0] {
    JOB_START,
    JOB_STEP,
    JOB_IDLE
  } job_kind_e;

  // Configuration registers.
  logic [CFG_DATA_BITS-1:0] dash_len_q;
  logic [CFG_DATA_BITS-1:0] gap_len_q;

  // Circle state.
  logic [RADIUS_BITS-1:0]   cur_x_q, cur_x_d;
  logic [RADIUS_BITS-1:0]   cur_y_q, cur_y_d;
  logic [DW-1:0]            dec_q, dec_d;
  logic [COORD_BITS-1:0]    ctr_x_q, ctr_x_d;
  logic [COORD_BITS-1:0]    ctr_y_q, ctr_y_d;
  logic                     pat_on_q, pat_on_d;
  logic [RUN_BITS-1:0]      run_q, run_d;
  logic                     active_q, active_d;

  // Job register: one accepted item whose results are being emitted.
  logic                     job_valid_q;
  job_kind_e                job_kind_q, job_kind_d;
  logic [COORD_BITS-1:0]    job_cx_q, job_cx_d;
  logic [COORD_BITS-1:0]    job_cy_q, job_cy_d;
  logic [RADIUS_BITS-1:0]   job_x_q, job_x_d;
  logic [RADIUS_BITS-1:0]   job_y_q, job_y_d;
  logic                     job_lit_q, job_lit_d;
  logic                     job_done_q, job_done_d;
  logic [2:0]               idx_q;

  // Output register.
  logic                     out_valid_q;
  logic [PW-1:0]            out_x_q, out_x_d;
  logic [PW-1:0]            out_y_q, out_y_d;
  logic                     out_lit_q;
  logic                     out_last_q, out_last_d;
  logic                     out_done_q;

  logic                     accept;
  logic                     load_out;
  logic                     is_last_pt;

  logic [RADIUS_BITS-1:0]   step_x;
  logic [RADIUS_BITS-1:0]   step_y;
  logic [DW-1:0]            step_dec;
  logic                     step_pat;
  logic [RUN_BITS-1:0]      step_run;
  logic                     step_done;

  logic [RADIUS_BITS-1:0]   off_a;
  logic [RADIUS_BITS-1:0]   off_b;
  logic                     neg_a;
  logic                     neg_b;

  // --------------------------------------------------------------------------
  // Configuration writes.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dash_len_q <= DASH_LENGTH_RST;
      gap_len_q  <= GAP_LENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DASH_LENGTH: dash_len_q <= cfg_data_i;
        CFG_GAP_LENGTH:  gap_len_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake. The next item is taken as the last result of the current job
  // moves into the output register.
  // --------------------------------------------------------------------------
  always_comb begin
    case (job_kind_q)
      JOB_START: is_last_pt = (idx_q == PT_START_LAST);
      JOB_STEP:  is_last_pt = (idx_q == PT_STEP_LAST);
      default:   is_last_pt = 1'b1;
    endcase
  end

  assign load_out    = job_valid_q && (!out_valid_q || pix_o.ready);
  assign req_i.ready = !job_valid_q || (load_out && is_last_pt);
  assign accept      = req_i.valid && req_i.ready;

  // --------------------------------------------------------------------------
  // Midpoint step and dash pattern for a step item.
  // --------------------------------------------------------------------------
  always_comb begin
    step_x = cur_x_q + RADIUS_BITS'(1);
    if (dec_q[DW-1]) begin
      // Decision negative: move east.
      step_y   = cur_y_q;
      step_dec = dec_q + (DW'(cur_x_q) << 1) + DEC_EAST_INC;
    end else begin
      // Decision not negative: move diagonally.
      step_y   = cur_y_q - RADIUS_BITS'(1);
      step_dec = dec_q + ((DW'(cur_x_q) - DW'(cur_y_q)) << 1) + DEC_DIAG_INC;
    end

    step_pat = pat_on_q;
    step_run = run_q;
    if (pat_on_q) begin
      if (run_q >= RUN_BITS'(dash_len_q)) begin
        step_pat = 1'b0;
        step_run = '0;
      end
    end else begin
      if (run_q >= RUN_BITS'(gap_len_q)) begin
        step_pat = 1'b1;
        step_run = '0;
      end
    end

    step_done = !(step_y > step_x);
  end

  // --------------------------------------------------------------------------
  // State and job updates on an accepted item.
  // --------------------------------------------------------------------------
  always_comb begin
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    dec_d      = dec_q;
    ctr_x_d    = ctr_x_q;
    ctr_y_d    = ctr_y_q;
    pat_on_d   = pat_on_q;
    run_d      = run_q;
    active_d   = active_q;

    job_kind_d = JOB_IDLE;
    job_cx_d   = '0;
    job_cy_d   = '0;
    job_x_d    = '0;
    job_y_d    = '0;
    job_lit_d  = 1'b0;
    job_done_d = 1'b1;

    if (req_i.req_type == REQ_START) begin
      cur_x_d    = '0;
      cur_y_d    = req_i.radius;
      dec_d      = DEC_ONE - DW'(req_i.radius);
      ctr_x_d    = req_i.center_x;
      ctr_y_d    = req_i.center_y;
      pat_on_d   = 1'b1;
      run_d      = RUN_BITS'(1);
      active_d   = (req_i.radius != '0);

      job_kind_d = JOB_START;
      job_cx_d   = req_i.center_x;
      job_cy_d   = req_i.center_y;
      job_y_d    = req_i.radius;
      job_lit_d  = 1'b1;
      job_done_d = (req_i.radius == '0);
    end else if (active_q) begin
      cur_x_d    = step_x;
      cur_y_d    = step_y;
      dec_d      = step_dec;
      pat_on_d   = step_pat;
      run_d      = step_run + RUN_BITS'(1);
      active_d   = !step_done;

      job_kind_d = JOB_STEP;
      job_cx_d   = ctr_x_q;
      job_cy_d   = ctr_y_q;
      job_x_d    = step_x;
      job_y_d    = step_y;
      job_lit_d  = step_pat;
      job_done_d = step_done;
    end
  end

  // --------------------------------------------------------------------------
  // Point selection: the eighth-symmetry of the current column.
  // --------------------------------------------------------------------------
  always_comb begin
    off_a = job_x_q;
    off_b = job_y_q;
    neg_a = 1'b0;
    neg_b = 1'b0;
    case (idx_q)
      3'd0: begin neg_a = 1'b0; neg_b = 1'b0; end
      3'd1: begin neg_a = 1'b0; neg_b = 1'b1; end
      3'd2: begin neg_a = 1'b1; neg_b = 1'b0; end
      3'd3: begin neg_a = 1'b1; neg_b = 1'b1; end
      3'd4: begin off_a = job_y_q; off_b = job_x_q; neg_a = 1'b0; neg_b = 1'b0; end
      3'd5: begin off_a = job_y_q; off_b = job_x_q; neg_a = 1'b1; neg_b = 1'b0; end
      3'd6: begin off_a = job_y_q; off_b = job_x_q; neg_a = 1'b0; neg_b = 1'b1; end
      3'd7: begin off_a = job_y_q; off_b = job_x_q; neg_a = 1'b1; neg_b = 1'b1; end
      default: ;
    endcase

    // Sums wrap at the output width.
    out_x_d = neg_a ? (PW'($signed(job_cx_q)) - PW'(off_a))
                    : (PW'($signed(job_cx_q)) + PW'(off_a));
    out_y_d = neg_b ? (PW'($signed(job_cy_q)) - PW'(off_b))
                    : (PW'($signed(job_cy_q)) + PW'(off_b));
    out_last_d = is_last_pt;
  end

  // --------------------------------------------------------------------------
  // Registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      dec_q       <= '0;
      ctr_x_q     <= '0;
      ctr_y_q     <= '0;
      pat_on_q    <= 1'b1;
      run_q       <= '0;
      active_q    <= 1'b0;
      job_valid_q <= 1'b0;
      job_kind_q  <= JOB_IDLE;
      idx_q       <= PT_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cur_x_q  <= cur_x_d;
        cur_y_q  <= cur_y_d;
        dec_q    <= dec_d;
        ctr_x_q  <= ctr_x_d;
        ctr_y_q  <= ctr_y_d;
        pat_on_q <= pat_on_d;
        run_q    <= run_d;
        active_q <= active_d;
      end

      if (accept) begin
        job_valid_q <= 1'b1;
        job_kind_q  <= job_kind_d;
        idx_q       <= PT_FIRST;
      end else if (load_out) begin
        if (is_last_pt) begin
          job_valid_q <= 1'b0;
        end else if (job_kind_q == JOB_START && idx_q == PT_START_JUMP) begin
          idx_q <= PT_START_NEXT;
        end else begin
          idx_q <= idx_q + 3'd1;
        end
      end

      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pix_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_cx_q   <= job_cx_d;
      job_cy_q   <= job_cy_d;
      job_x_q    <= job_x_d;
      job_y_q    <= job_y_d;
      job_lit_q  <= job_lit_d;
      job_done_q <= job_done_d;
    end
    if (load_out) begin
      out_x_q    <= out_x_d;
      out_y_q    <= out_y_d;
      out_lit_q  <= job_lit_q;
      out_last_q <= out_last_d;
      out_done_q <= job_done_q;
    end
  end

  assign pix_o.valid    = out_valid_q;
  assign pix_o.pixel_x  = out_x_q;
  assign pix_o.pixel_y  = out_y_q;
  assign pix_o.lit      = out_lit_q;
  assign pix_o.last     = out_last_q;
  assign pix_o.done_res = out_done_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------

  // A circle in progress always has its column strictly inside the octant.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (cur_y_q > cur_x_q))
    else $error("circle in progress outside the first octant");

  // A start job only visits the four axis points.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_q && job_kind_q == JOB_START) |->
      (idx_q == 3'd0 || idx_q == 3'd1 || idx_q == 3'd4 || idx_q == 3'd5))
    else $error("start job at a non-axis point");

  // A new item is only taken once the current job hands over its last result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && job_valid_q) |-> (load_out && is_last_pt))
    else $error("item accepted over a job still emitting");

  // Loading the final result of a job marks it last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && is_last_pt) |=> (pix_o.valid && pix_o.last))
    else $error("final result of a job not marked last");

endmodule
